/* hdl/kes_pkg.sv */
// ----------------------------------------------------------------------------
// kes_pkg: shared definitions for the keyframe envelope evaluator
// Table geometry, arithmetic widths, datapath operation codes and the
// command and status bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package kes_pkg;

	// Keyframe table geometry.
	localparam int MAX_POINTS = 8;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int N_W        = $clog2(MAX_POINTS + 1);
	localparam int CNT_W      = 4;

	// Field widths.
	localparam int TIME_W  = 16;
	localparam int LEVEL_W = 16;
	localparam int PIDX_W  = 3;

	localparam logic [LEVEL_W-1:0] LEVEL_ONE = 16'd32768;

	// Segment position and polynomial arithmetic.
	localparam int FRAC_BITS = 14;
	localparam int STEP_W    = $clog2(FRAC_BITS);
	localparam int COEF_W    = 24;
	localparam int LO_W      = 26;
	localparam int MUL_A_W   = 27;
	localparam int MUL_B_W   = FRAC_BITS + 1;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int ACC_W     = 66;
	localparam int SHIFT_OUT = 3 * FRAC_BITS;
	localparam int HI_W      = ACC_W - SHIFT_OUT;

	// Final divide by six: y / 6 == (y * RECIP6) >> RECIP_SH for y below 2^19.
	localparam int RND_W    = 18;
	localparam int RECIP_W  = 19;
	localparam int RECIP_SH = 21;
	localparam logic [RECIP_W-1:0] RECIP6 = 19'd349526;
	localparam logic [RND_W-1:0]   Y_MAX  = 18'd196608;

	// Datapath operations.
	typedef logic [4:0] dp_op_t;
	localparam dp_op_t OP_NONE     = 5'd0;
	localparam dp_op_t OP_WRITE    = 5'd1;
	localparam dp_op_t OP_LOAD_Q   = 5'd2;
	localparam dp_op_t OP_RES_ZERO = 5'd3;
	localparam dp_op_t OP_RES_SAT  = 5'd4;
	localparam dp_op_t OP_PREV     = 5'd5;
	localparam dp_op_t OP_SEG      = 5'd6;
	localparam dp_op_t OP_P0       = 5'd7;
	localparam dp_op_t OP_P1       = 5'd8;
	localparam dp_op_t OP_PP       = 5'd9;
	localparam dp_op_t OP_PN       = 5'd10;
	localparam dp_op_t OP_DIV      = 5'd11;
	localparam dp_op_t OP_COEF     = 5'd12;
	localparam dp_op_t OP_MUL_C3   = 5'd13;
	localparam dp_op_t OP_ADD_C2   = 5'd14;
	localparam dp_op_t OP_MUL_LO   = 5'd15;
	localparam dp_op_t OP_MUL_HI   = 5'd16;
	localparam dp_op_t OP_ADD_C1   = 5'd17;
	localparam dp_op_t OP_ADD_C0   = 5'd18;
	localparam dp_op_t OP_ROUND    = 5'd19;
	localparam dp_op_t OP_SCALE    = 5'd20;

	typedef struct packed {
		dp_op_t           op;
		logic [IDX_W-1:0] rd_addr;
		logic             out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic q_le;
		logic q_ge;
		logic prev_le;
		logic out_busy;
	} dp_stat_t;

	function automatic logic [LEVEL_W-1:0] sat_level(input logic [LEVEL_W-1:0] v);
		return (v > LEVEL_ONE) ? LEVEL_ONE : v;
	endfunction

endpackage

/* hdl/kes_dp.sv */
// ----------------------------------------------------------------------------
// kes_dp: envelope evaluator datapath
// Keyframe tables, segment search compares, restoring divider for the
// segment position, shared multiplier for the Horner polynomial, rounding
// and the output register.
// ----------------------------------------------------------------------------
module kes_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  kes_pkg::dp_cmd_t               cmd,
	output kes_pkg::dp_stat_t              stat,
	input  logic [kes_pkg::PIDX_W-1:0]     point_index,
	input  logic [kes_pkg::TIME_W-1:0]     point_time,
	input  logic [kes_pkg::LEVEL_W-1:0]    point_level,
	input  logic [kes_pkg::TIME_W-1:0]     query_time,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [kes_pkg::LEVEL_W-1:0]    level
);
	import kes_pkg::*;

	logic [TIME_W-1:0]  time_tab_q  [MAX_POINTS];
	logic [LEVEL_W-1:0] level_tab_q [MAX_POINTS];
	logic               wr_ok;
	logic [IDX_W-1:0]   wr_idx;
	logic [TIME_W-1:0]  rd_time;
	logic [LEVEL_W-1:0] rd_level;

	logic [TIME_W-1:0]    q_q;
	logic [TIME_W-1:0]    prev_q;
	logic [TIME_W-1:0]    rem_q;
	logic [TIME_W-1:0]    den_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [TIME_W:0]      rem_x2;
	logic [TIME_W:0]      rem_diff;
	logic                 div_ge;

	logic [LEVEL_W-1:0] p0_q, p1_q, pp_q, pn_q;
	logic signed [COEF_W-1:0] p0s, p1s, pps, pns;
	logic signed [COEF_W-1:0] c0_n, c1_n, c2_n, c3_n;
	logic signed [COEF_W-1:0] c0_q, c1_q, c2_q, c3_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;
	logic signed [MUL_P_W-1:0] mul_q;
	logic signed [ACC_W-1:0]   acc_q;

	logic                     s_pos;
	logic [HI_W:0]            y_full;
	logic [RND_W-1:0]         y_q;
	logic [RND_W+RECIP_W-1:0] scaled;
	logic [LEVEL_W-1:0]       res_q;
	logic [LEVEL_W-1:0]       level_q;
	logic                     out_valid_q;

	// Keyframe tables: one write port, one read port.
	assign wr_ok  = (int'(point_index) < MAX_POINTS);
	assign wr_idx = IDX_W'(point_index);

	always_ff @(posedge clk) begin
		if (cmd.op == OP_WRITE && wr_ok) begin
			time_tab_q[wr_idx]  <= point_time;
			level_tab_q[wr_idx] <= point_level;
		end
	end

	assign rd_time  = time_tab_q[cmd.rd_addr];
	assign rd_level = level_tab_q[cmd.rd_addr];

	assign stat.q_le     = (q_q <= rd_time);
	assign stat.q_ge     = (q_q >= rd_time);
	assign stat.prev_le  = (prev_q <= q_q);
	assign stat.out_busy = out_valid_q && out_stall;

	// One quotient bit per step; the remainder always stays below the divisor.
	assign rem_x2   = {rem_q, 1'b0};
	assign rem_diff = rem_x2 - {1'b0, den_q};
	assign div_ge   = (rem_x2 >= {1'b0, den_q});

	// Power-basis coefficients of the Bezier with Catmull-Rom inner points.
	assign p0s  = signed'(COEF_W'(p0_q));
	assign p1s  = signed'(COEF_W'(p1_q));
	assign pps  = signed'(COEF_W'(pp_q));
	assign pns  = signed'(COEF_W'(pn_q));
	assign c0_n = (p0s <<< 2) + (p0s <<< 1);
	assign c1_n = (p1s <<< 1) + p1s - (pps <<< 1) - pps;
	assign c2_n = (p1s <<< 3) + (p1s <<< 2) + (pps <<< 2) + (pps <<< 1)
	            + p0s - (p0s <<< 4) - (pns <<< 1) - pns;
	assign c3_n = (p0s <<< 3) + p0s - (p1s <<< 3) - p1s
	            + (pns <<< 1) + pns - (pps <<< 1) - pps;

	// Shared multiplier; the accumulator is multiplied in a low and a high half.
	always_comb begin
		unique case (cmd.op)
			OP_MUL_C3: mul_a = MUL_A_W'(c3_q);
			OP_MUL_LO: mul_a = signed'({1'b0, acc_q[LO_W-1:0]});
			default:   mul_a = acc_q[LO_W+MUL_A_W-1:LO_W];
		endcase
	end

	assign mul_b = signed'({1'b0, frac_q});
	assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

	assign s_pos  = !acc_q[ACC_W-1] && (acc_q != '0);
	assign y_full = {1'b0, acc_q[ACC_W-1:SHIFT_OUT]} + (HI_W+1)'(3);
	assign scaled = y_q * RECIP6;

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD_Q:   q_q <= query_time;
			OP_RES_ZERO: res_q <= '0;
			OP_RES_SAT:  res_q <= sat_level(rd_level);
			OP_PREV:     prev_q <= rd_time;
			OP_SEG: begin
				rem_q  <= q_q - prev_q;
				den_q  <= rd_time - prev_q;
				frac_q <= '0;
			end
			OP_P0: p0_q <= rd_level;
			OP_P1: p1_q <= rd_level;
			OP_PP: pp_q <= rd_level;
			OP_PN: pn_q <= rd_level;
			OP_DIV: begin
				rem_q  <= div_ge ? rem_diff[TIME_W-1:0] : rem_x2[TIME_W-1:0];
				frac_q <= {frac_q[FRAC_BITS-2:0], div_ge};
			end
			OP_COEF: begin
				c0_q <= c0_n;
				c1_q <= c1_n;
				c2_q <= c2_n;
				c3_q <= c3_n;
			end
			OP_MUL_C3: mul_q <= mul_p;
			OP_ADD_C2: acc_q <= ACC_W'(mul_q) + (ACC_W'(c2_q) <<< FRAC_BITS);
			OP_MUL_LO: mul_q <= mul_p;
			OP_MUL_HI: begin
				acc_q <= ACC_W'(mul_q);
				mul_q <= mul_p;
			end
			OP_ADD_C1: acc_q <= acc_q + (ACC_W'(mul_q) <<< LO_W)
			                  + (ACC_W'(c1_q) <<< (2 * FRAC_BITS));
			OP_ADD_C0: acc_q <= acc_q + (ACC_W'(mul_q) <<< LO_W)
			                  + (ACC_W'(c0_q) <<< SHIFT_OUT);
			OP_ROUND: begin
				if (!s_pos) begin
					y_q <= '0;
				end else if (y_full >= (HI_W+1)'(Y_MAX)) begin
					y_q <= Y_MAX;
				end else begin
					y_q <= y_full[RND_W-1:0];
				end
			end
			OP_SCALE: res_q <= scaled[RECIP_SH +: LEVEL_W];
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			level_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign level     = level_q;

endmodule

/* hdl/kes_ctrl.sv */
// ----------------------------------------------------------------------------
// kes_ctrl: envelope evaluator controller
// Holds the point count register and sequences the end checks, the segment
// search, the level reads, the divider and the polynomial steps.
// ----------------------------------------------------------------------------
module kes_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       req_type,
	output logic                       in_stall,
	input  logic                       cfg_valid,
	input  logic [kes_pkg::CNT_W-1:0]  cfg_data,
	output logic                       cfg_ready,
	input  kes_pkg::dp_stat_t          stat,
	output kes_pkg::dp_cmd_t           cmd
);
	import kes_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_CHK0 = 5'd1;
	localparam logic [4:0] S_CHKN = 5'd2;
	localparam logic [4:0] S_SRCH = 5'd3;
	localparam logic [4:0] S_LAST = 5'd4;
	localparam logic [4:0] S_LP0  = 5'd5;
	localparam logic [4:0] S_LP1  = 5'd6;
	localparam logic [4:0] S_LPP  = 5'd7;
	localparam logic [4:0] S_LPN  = 5'd8;
	localparam logic [4:0] S_DIV  = 5'd9;
	localparam logic [4:0] S_COEF = 5'd10;
	localparam logic [4:0] S_MC3  = 5'd11;
	localparam logic [4:0] S_AC2  = 5'd12;
	localparam logic [4:0] S_ML2  = 5'd13;
	localparam logic [4:0] S_MH2  = 5'd14;
	localparam logic [4:0] S_AC1  = 5'd15;
	localparam logic [4:0] S_ML3  = 5'd16;
	localparam logic [4:0] S_MH3  = 5'd17;
	localparam logic [4:0] S_AC0  = 5'd18;
	localparam logic [4:0] S_RND  = 5'd19;
	localparam logic [4:0] S_SCL  = 5'd20;
	localparam logic [4:0] S_RES  = 5'd21;

	logic [4:0]        state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	logic [N_W-1:0]    n_q, n_d;
	logic [IDX_W-1:0]  k_q, k_d;
	logic [IDX_W-1:0]  seg_q, seg_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic [N_W-1:0]    n_m1;
	logic [IDX_W-1:0]  last_idx;
	logic [IDX_W-1:0]  seg_inc;
	logic              pn_at_end;

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);

	assign n_m1      = n_q - N_W'(1);
	assign last_idx  = n_m1[IDX_W-1:0];
	assign seg_inc   = seg_q + IDX_W'(1);
	assign pn_at_end = (N_W'(seg_q) + N_W'(2) >= n_q);

	always_comb begin
		state_d      = state_q;
		n_d          = n_q;
		k_d          = k_q;
		seg_d        = seg_q;
		step_d       = step_q;
		cmd.op       = OP_NONE;
		cmd.rd_addr  = '0;
		cmd.out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (!req_type) begin
						cmd.op = OP_WRITE;
					end else begin
						cmd.op  = OP_LOAD_Q;
						n_d     = (int'(count_q) > MAX_POINTS) ? N_W'(MAX_POINTS)
						                                       : N_W'(count_q);
						state_d = S_CHK0;
					end
				end
			end
			S_CHK0: begin
				cmd.rd_addr = '0;
				if (n_q == '0) begin
					cmd.op  = OP_RES_ZERO;
					state_d = S_RES;
				end else if (n_q == N_W'(1) || stat.q_le) begin
					cmd.op  = OP_RES_SAT;
					state_d = S_RES;
				end else begin
					cmd.op  = OP_PREV;
					state_d = S_CHKN;
				end
			end
			S_CHKN: begin
				cmd.rd_addr = last_idx;
				if (stat.q_ge) begin
					cmd.op  = OP_RES_SAT;
					state_d = S_RES;
				end else begin
					k_d     = IDX_W'(1);
					state_d = S_SRCH;
				end
			end
			S_SRCH: begin
				cmd.rd_addr = k_q;
				if (stat.prev_le && !stat.q_ge) begin
					cmd.op  = OP_SEG;
					seg_d   = k_q - IDX_W'(1);
					state_d = S_LP0;
				end else begin
					cmd.op = OP_PREV;
					if (N_W'(k_q) == n_m1) begin
						state_d = S_LAST;
					end else begin
						k_d = k_q + IDX_W'(1);
					end
				end
			end
			S_LAST: begin
				cmd.rd_addr = last_idx;
				cmd.op      = OP_RES_SAT;
				state_d     = S_RES;
			end
			S_LP0: begin
				cmd.rd_addr = seg_q;
				cmd.op      = OP_P0;
				state_d     = S_LP1;
			end
			S_LP1: begin
				cmd.rd_addr = seg_inc;
				cmd.op      = OP_P1;
				state_d     = S_LPP;
			end
			S_LPP: begin
				cmd.rd_addr = (seg_q == '0) ? seg_q : seg_q - IDX_W'(1);
				cmd.op      = OP_PP;
				state_d     = S_LPN;
			end
			S_LPN: begin
				cmd.rd_addr = pn_at_end ? seg_inc : seg_q + IDX_W'(2);
				cmd.op      = OP_PN;
				step_d      = '0;
				state_d     = S_DIV;
			end
			S_DIV: begin
				cmd.op = OP_DIV;
				step_d = step_q + STEP_W'(1);
				if (step_q == STEP_W'(FRAC_BITS - 1)) begin
					state_d = S_COEF;
				end
			end
			S_COEF: begin
				cmd.op  = OP_COEF;
				state_d = S_MC3;
			end
			S_MC3: begin
				cmd.op  = OP_MUL_C3;
				state_d = S_AC2;
			end
			S_AC2: begin
				cmd.op  = OP_ADD_C2;
				state_d = S_ML2;
			end
			S_ML2: begin
				cmd.op  = OP_MUL_LO;
				state_d = S_MH2;
			end
			S_MH2: begin
				cmd.op  = OP_MUL_HI;
				state_d = S_AC1;
			end
			S_AC1: begin
				cmd.op  = OP_ADD_C1;
				state_d = S_ML3;
			end
			S_ML3: begin
				cmd.op  = OP_MUL_LO;
				state_d = S_MH3;
			end
			S_MH3: begin
				cmd.op  = OP_MUL_HI;
				state_d = S_AC0;
			end
			S_AC0: begin
				cmd.op  = OP_ADD_C0;
				state_d = S_RND;
			end
			S_RND: begin
				cmd.op  = OP_ROUND;
				state_d = S_SCL;
			end
			S_SCL: begin
				cmd.op  = OP_SCALE;
				state_d = S_RES;
			end
			S_RES: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			n_q     <= '0;
			k_q     <= '0;
			seg_q   <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			n_q     <= n_d;
			k_q     <= k_d;
			seg_q   <= seg_d;
			step_q  <= step_d;
			if (cfg_valid && cfg_ready) begin
				count_q <= cfg_data;
			end
		end
	end

`ifndef SYNTH
	// An accepted evaluate item blocks the input until its result is handed over.
	a_eval_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid && req_type) |=> in_stall)
		else $error("evaluate item accepted but input not stalled");

	// The search never reads past the last point in use.
	a_srch_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH) |-> (k_q != '0 && N_W'(k_q) < n_q))
		else $error("segment search index out of range");

	// A found segment leaves room for its end point.
	a_seg_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LP0) |-> (N_W'(seg_q) + N_W'(2) <= n_q))
		else $error("segment index out of range");

	// The divider runs exactly the fraction width.
	a_div_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (step_q < STEP_W'(FRAC_BITS)))
		else $error("divider step count overrun");

	// A result is never loaded over one that is still held by the consumer.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !stat.out_busy)
		else $error("output register overwritten while stalled");
`endif

endmodule

/* hdl/keyframe_envelope_spline_eval.sv */
// ----------------------------------------------------------------------------
// keyframe_envelope_spline_eval: keyframe intensity envelope evaluator
// Stores up to eight time/level keyframes and returns the envelope level at
// a query time, using a cubic Bezier with Catmull-Rom tangents per segment.
// ----------------------------------------------------------------------------
// A write item (req_type 0) stores one keyframe and gives no result; it can
// be followed by another item in the next cycle. An evaluate item (req_type
// 1) gives exactly one level item and is handled one at a time: the input
// stalls from the cycle after acceptance until its result has moved into the
// output register. An empty table, a query at or before the first point, or
// at or beyond the last point in use is answered from the end checks alone.
// When out-of-order keyframes leave no segment around the query, the whole
// search runs and the level of the last point in use is returned. An
// interior query goes through acceptance, the two end checks, the segment
// search (1 to 7 segments tried), 4 level reads, the divider for the 14-bit
// segment position (one quotient bit per cycle), the polynomial work on one
// shared 27 by 15 bit multiplier and the result handoff. The handoff waits
// while the previous level is still held in the output register by
// out_stall.
// The keyframe table has one read port, which sets the length of the search
// and the level reads. The output register lets a new item be taken while
// the previous level still waits on out_stall. Keyframes must be written in
// ascending time and an entry must be written before a point_count that
// covers it is used; point_count above eight acts as eight. The config
// register is written only while the block is idle. There is no clearing
// pass after reset.
// ----------------------------------------------------------------------------
module keyframe_envelope_spline_eval (
	input  logic                           clk,
	input  logic                           arst_n,
	// Request channel.
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           req_type,
	input  logic [kes_pkg::PIDX_W-1:0]     point_index,
	input  logic [kes_pkg::TIME_W-1:0]     point_time,
	input  logic [kes_pkg::LEVEL_W-1:0]    point_level,
	input  logic [kes_pkg::TIME_W-1:0]     query_time,
	// Result channel.
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [kes_pkg::LEVEL_W-1:0]    level,
	// Point count register write.
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [kes_pkg::CNT_W-1:0]      cfg_data
);
	import kes_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// The controller owns sequencing and the point count; every item the
	// datapath handles is steered by the command bundle alone.
	kes_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.req_type  (req_type),
		.in_stall  (in_stall),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath holds the keyframe tables, the divider, the polynomial
	// accumulator and the output register.
	kes_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.point_index (point_index),
		.point_time  (point_time),
		.point_level (point_level),
		.query_time  (query_time),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.level       (level)
	);

endmodule

/* tb/tb_keyframe_envelope_spline_eval.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyframe_envelope_spline_eval: self-checking bench for the envelope block
// Loads keyframe tables, sweeps the point count and checks every evaluated
// level against a cycle-free model of the Catmull-Rom Bezier envelope.
// ----------------------------------------------------------------------------
module tb_keyframe_envelope_spline_eval;

	import kes_pkg::*;

	// Request kinds carried by req_type.
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_EVAL  = 1'b1;

	localparam int RANDOM_ITEMS  = 950;
	// Cycles to let the block finish a write that produced no result.
	localparam int SETTLE_CYCLES = 60;
	// Items at the end of the run that are sent without any idling.
	localparam int CALM_ITEMS    = 150;

	// The scoreboard keeps its own copy of the keyframe table and the point
	// count, predicts the level of every accepted evaluate item and checks
	// the level items in order of arrival.
	class envelope_checker;
		logic [TIME_W-1:0]  key_time [MAX_POINTS];
		logic [LEVEL_W-1:0] key_level [MAX_POINTS];
		logic [CNT_W-1:0]   point_count;
		logic [LEVEL_W-1:0] pending_levels [$];
		int                 errors;

		function new();
			point_count = '0;
			errors = 0;
			foreach (key_time[k]) begin
				key_time[k] = '0;
				key_level[k] = '0;
			end
		endfunction

		function logic [LEVEL_W-1:0] saturate_q15(longint v);
			return (v > LEVEL_ONE) ? LEVEL_ONE : LEVEL_W'(v);
		endfunction

		// Bernstein form of the segment, scaled by six so that the tangent
		// control points stay integral; rounded half up at the end.
		function logic [LEVEL_W-1:0] bezier_level(longint frac, longint p0, longint p1,
				longint pp, longint pn);
			longint u, a, b, c, d, s, r;
			u = (longint'(1) << FRAC_BITS) - frac;
			a = 6 * p0;
			b = 6 * p0 + p1 - pp;
			c = 6 * p1 + p0 - pn;
			d = 6 * p1;
			s = a * (u * u * u) + 3 * b * (u * u * frac) + 3 * c * (u * frac * frac)
				+ d * (frac * frac * frac);
			if (s <= 0)
				return '0;
			r = (s + (longint'(3) << (3 * FRAC_BITS))) / (longint'(6) << (3 * FRAC_BITS));
			return saturate_q15(r);
		endfunction

		function logic [LEVEL_W-1:0] envelope_level(logic [TIME_W-1:0] q);
			int     n, k, seg;
			bit     found;
			longint t0, t1, p0, p1, pp, pn, frac;
			n = (point_count > MAX_POINTS) ? MAX_POINTS : int'(point_count);
			if (n == 0)
				return '0;
			if (n == 1 || q <= key_time[0])
				return saturate_q15(key_level[0]);
			if (q >= key_time[n-1])
				return saturate_q15(key_level[n-1]);
			found = 1'b0;
			seg = 0;
			for (k = 0; k + 1 < n && !found; k++) begin
				if (key_time[k] <= q && q < key_time[k+1]) begin
					found = 1'b1;
					seg = k;
				end
			end
			if (!found)
				return saturate_q15(key_level[n-1]);
			t0 = key_time[seg];
			t1 = key_time[seg+1];
			p0 = key_level[seg];
			p1 = key_level[seg+1];
			pp = (seg == 0) ? p0 : longint'(key_level[seg-1]);
			pn = (seg + 2 >= n) ? p1 : longint'(key_level[seg+2]);
			if (t1 <= t0)
				return saturate_q15(p1);
			frac = ((longint'(q) - t0) << FRAC_BITS) / (t1 - t0);
			return bezier_level(frac, p0, p1, pp, pn);
		endfunction

		task report_mismatch(string what);
			errors++;
			$display("%0t MISMATCH %s", $time, what);
		endtask

		function void note_point_count(logic [CNT_W-1:0] n);
			point_count = n;
		endfunction

		function void note_item(logic rt, logic [PIDX_W-1:0] idx, logic [TIME_W-1:0] pt,
				logic [LEVEL_W-1:0] pl, logic [TIME_W-1:0] qt);
			if (rt == REQ_WRITE) begin
				if (idx < MAX_POINTS) begin
					key_time[idx] = pt;
					key_level[idx] = pl;
				end
			end else begin
				pending_levels.insert(pending_levels.size(), envelope_level(qt));
			end
		endfunction

		task check_level(logic [LEVEL_W-1:0] got);
			logic [LEVEL_W-1:0] want;
			if (pending_levels.size() == 0) begin
				report_mismatch($sformatf("level %0d with no evaluate item waiting", got));
			end else begin
				want = pending_levels.pop_front();
				if (got !== want)
					report_mismatch($sformatf("level %0d, expected %0d", got, want));
			end
		endtask

		task check_drained();
			if (pending_levels.size() != 0)
				report_mismatch($sformatf("%0d expected levels never arrived",
					pending_levels.size()));
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                req_type;
	logic [PIDX_W-1:0]   point_index;
	logic [TIME_W-1:0]   point_time;
	logic [LEVEL_W-1:0]  point_level;
	logic [TIME_W-1:0]   query_time;
	logic                out_valid;
	logic                out_stall;
	logic [LEVEL_W-1:0]  level;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CNT_W-1:0]    cfg_data;

	envelope_checker sb;
	int              items_sent;
	int              directed_items;
	// Set for the last stretch of the run, where neither side idles.
	bit              calm_tail;

	keyframe_envelope_spline_eval dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.point_index (point_index),
		.point_time  (point_time),
		.point_level (point_level),
		.query_time  (query_time),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.level       (level),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The result side stalls in random bursts. A burst never runs straight
	// into the next one: runs of free cycles of random length fall between
	// bursts.
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm_tail && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Every level item taken from the block is checked at the edge where it
	// is accepted. Outputs are read right at the rising edge, before the
	// block's own registers update.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_level(level);
	end

	// Present one item at a falling edge, optionally after an idle burst, and
	// hold it until a rising edge sees in_stall low. Valid stays high into the
	// next item when no gap follows, so it is assigned once per step.
	task automatic send_item(input logic rt, input logic [PIDX_W-1:0] idx,
			input logic [TIME_W-1:0] pt, input logic [LEVEL_W-1:0] pl,
			input logic [TIME_W-1:0] qt);
		int gap;
		gap = (!calm_tail && $urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		req_type <= rt;
		point_index <= idx;
		point_time <= pt;
		point_level <= pl;
		query_time <= qt;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_item(rt, idx, pt, pl, qt);
		items_sent++;
	endtask

	// Levels lean on the two ends of the Q1.15 range, which push the curve
	// into both saturation limits.
	function automatic logic [LEVEL_W-1:0] pick_level();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return LEVEL_ONE;
			default: return LEVEL_W'($urandom_range(0, 32768));
		endcase
	endfunction

	// The fields that an item does not use still carry random values.
	task automatic write_point(input logic [PIDX_W-1:0] idx, input logic [TIME_W-1:0] t,
			input logic [LEVEL_W-1:0] lv);
		send_item(REQ_WRITE, idx, t, lv, TIME_W'($urandom));
	endtask

	task automatic eval_at(input logic [TIME_W-1:0] q);
		send_item(REQ_EVAL, PIDX_W'($urandom), TIME_W'($urandom), pick_level(), q);
	endtask

	// Drop valid, wait for every outstanding level, then give a trailing write
	// time to complete. Only after this is the block idle for a register write.
	task automatic settle_block();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_levels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_point_count(input logic [CNT_W-1:0] n);
		settle_block();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= n;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.note_point_count(n);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Fill all eight slots. Most tables ascend with a random step size, which
	// may repeat a time; a few are scrambled to cover out-of-order keyframes.
	task automatic load_random_table();
		logic [TIME_W-1:0] t;
		int                nt, stepmax, k;
		bit                scrambled;
		scrambled = ($urandom_range(0, 7) == 0);
		t = TIME_W'($urandom_range(0, 3000));
		case ($urandom_range(0, 2))
			0:       stepmax = 20;
			1:       stepmax = 2000;
			default: stepmax = 8000;
		endcase
		for (k = 0; k < MAX_POINTS; k++) begin
			write_point(PIDX_W'(k), scrambled ? TIME_W'($urandom) : t, pick_level());
			nt = int'(t) + $urandom_range(0, stepmax);
			t = (nt > 65535) ? 16'hFFFF : 16'(nt);
		end
	endtask

	// Queries mostly fall inside the span in use, with hits on exact keyframe
	// times, the ends and their close neighbors, and some fully random times.
	function automatic logic [TIME_W-1:0] random_query();
		int n, k;
		n = (sb.point_count > MAX_POINTS) ? MAX_POINTS : int'(sb.point_count);
		if (n == 0)
			return TIME_W'($urandom);
		k = $urandom_range(0, n - 1);
		case ($urandom_range(0, 19)) inside
			[0:11]:  return TIME_W'($urandom_range(sb.key_time[0], sb.key_time[n-1]));
			[12:14]: return TIME_W'(int'(sb.key_time[k]) + $urandom_range(0, 4) - 2);
			15:      return sb.key_time[0];
			16:      return sb.key_time[n-1];
			default: return TIME_W'($urandom);
		endcase
	endfunction

	initial begin
		logic [CNT_W-1:0] cnt;
		int               burst, wait_cycles;

		sb = new();
		items_sent = 0;
		calm_tail = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_WRITE;
		point_index = '0;
		point_time = '0;
		point_level = '0;
		query_time = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// An empty table reads as zero at both ends of the time range.
		eval_at(16'd0);
		eval_at(16'hFFFF);

		// A table that spans the full time range and swings the level between
		// zero and one, so the curve overshoots on both sides.
		write_point(3'd0, 16'd0, LEVEL_ONE);
		write_point(3'd1, 16'd100, 16'd0);
		write_point(3'd2, 16'd2000, LEVEL_ONE);
		write_point(3'd3, 16'd2001, 16'd0);
		write_point(3'd4, 16'd30000, 16'd16384);
		write_point(3'd5, 16'd40000, LEVEL_ONE);
		write_point(3'd6, 16'd50000, 16'd0);
		write_point(3'd7, 16'hFFFF, LEVEL_ONE);

		// With a single point, any query returns that point's level.
		write_point_count(4'd1);
		eval_at(16'hFFFF);

		// Full table: both ends, the first segment (mirrored previous level),
		// an exact keyframe time, the last segment (mirrored next level) and
		// a wide interior segment.
		write_point_count(4'd8);
		eval_at(16'd0);
		eval_at(16'hFFFF);
		eval_at(16'd50);
		eval_at(16'd2000);
		eval_at(16'd64000);
		eval_at(16'd35000);

		// A count beyond the table size behaves as a full table.
		write_point_count(4'd15);
		eval_at(16'd45000);

		// Out-of-order keyframe times: the first segment that brackets the
		// query is used, even when a later segment brackets it too.
		write_point(3'd3, 16'd1, LEVEL_ONE);
		eval_at(16'd1500);
		eval_at(16'd20000);
		directed_items = items_sent;

		// Random phases: each sets a point count while the block is idle, then
		// usually reloads the table and sends a run of mostly evaluate items
		// with the odd stray keyframe write mixed in.
		while (items_sent - directed_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0:       cnt = 4'd0;
				1:       cnt = 4'd1;
				2:       cnt = 4'd2;
				3:       cnt = CNT_W'($urandom_range(9, 15));
				default: cnt = CNT_W'($urandom_range(3, 8));
			endcase
			write_point_count(cnt);
			if ($urandom_range(0, 3) != 0)
				load_random_table();
			burst = $urandom_range(30, 90);
			while (burst > 0 && items_sent - directed_items < RANDOM_ITEMS) begin
				calm_tail = (items_sent - directed_items >= RANDOM_ITEMS - CALM_ITEMS);
				if ($urandom_range(0, 9) == 0)
					write_point(PIDX_W'($urandom_range(0, 7)), TIME_W'($urandom),
						pick_level());
				else
					eval_at(random_query());
				burst--;
			end
		end

		// Drain, with a bound, and leave room for anything still in flight.
		@(negedge clk);
		in_valid <= 1'b0;
		for (wait_cycles = 0; wait_cycles < 20000 && sb.pending_levels.size() != 0;
				wait_cycles++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		sb.check_drained();
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog: several times the slowest legal run.
	initial begin
		#4000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

/* files.f */
hdl/kes_pkg.sv
hdl/kes_dp.sv
hdl/kes_ctrl.sv
hdl/keyframe_envelope_spline_eval.sv
tb/tb_keyframe_envelope_spline_eval.sv
